/* rtl/online_softmax_attention_row_top_assert.svh */
// Assertion macros for the online softmax attention row block
`ifndef ONLINE_SOFTMAX_ATTENTION_ROW_TOP_ASSERT_SVH
`define ONLINE_SOFTMAX_ATTENTION_ROW_TOP_ASSERT_SVH
`ifndef SYNTH
`define OSA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define OSA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define OSA_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define OSA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/osa_pkg.sv */
// Shared types, constants and the exponent table of the attention row block
package osa_pkg;

   localparam int DIM_MAX        = 64;
   localparam int IDX_W          = 6;
   localparam int DIM_W          = 7;
   localparam int EXP_TABLE_BITS = 8;
   localparam int EXP_TABLE_SIZE = 1 << EXP_TABLE_BITS;
   localparam int DIV_STEPS      = 49;

   typedef enum logic [1:0] {
      REQ_QUERY  = 2'd0,
      REQ_KEY    = 2'd1,
      REQ_VALUE  = 2'd2,
      REQ_FINISH = 2'd3
   } req_kind_type;

   typedef enum logic [0:0] {
      CSR_DIM   = 1'b0,
      CSR_SCALE = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_K_MUL,
      ST_K_ACC,
      ST_K_SCALE,
      ST_K_CMP,
      ST_K_UPD,
      ST_V_MUL,
      ST_V_WR,
      ST_F_RD,
      ST_F_START,
      ST_F_WAIT
   } state_type;

   typedef struct packed {
      logic load;
      logic q_we;
      logic k_mul;
      logic k_acc;
      logic k_scale;
      logic k_cmp;
      logic k_upd;
      logic v_mul;
      logic v_wr;
      logic f_clr;
      logic f_start;
      logic f_out;
      logic f_next;
      logic row_clr;
   } cmd_type;

   typedef struct packed {
      req_kind_type kind;
      logic         idx_ok;
      logic         idx_last;
      logic         cnt_last;
      logic         div_done;
   } status_type;

   typedef logic [16:0] exp_tab_type [EXP_TABLE_SIZE];

   // exp(-i*step) in Q1.16, built from a truncated Taylor series of exp(-step)
   function automatic exp_tab_type build_exp_tab();
      logic [63:0] h;
      logic [63:0] term;
      logic [63:0] e;
      longint      r;
      exp_tab_type t;
      h    = 64'd1 << (34 - EXP_TABLE_BITS);
      term = 64'd1 << 30;
      r    = longint'(64'd1 << 30);
      e    = 64'd1 << 30;
      for (int k = 1; k <= 24; k++) begin
         term = ((term * h) >> 30) / 64'(k);
         if ((k % 2) == 1) r = r - longint'(term);
         else r = r + longint'(term);
      end
      if (r < 0) r = 0;
      for (int i = 0; i < EXP_TABLE_SIZE; i++) begin
         if (i > 0) e = (e * 64'(r) + (64'd1 << 29)) >> 30;
         t[i] = 17'((e + (64'd1 << 13)) >> 14);
      end
      return t;
   endfunction

   localparam exp_tab_type EXP_TAB = build_exp_tab();

endpackage

/* rtl/osa_div.sv */
// Restoring divider, one quotient bit per cycle
module osa_div
   import osa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [48:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [48:0] quotient
);

   logic [48:0] dvd_ff, dvd_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [5:0]  step_ff, step_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [32:0] rem_sh;
   logic        fits;

   // shift in one dividend bit and try the subtract
   always_comb begin
      rem_sh  = {rem_ff[31:0], dvd_ff[48]};
      fits    = rem_sh >= {1'b0, dsr_ff};
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         rem_in  = fits ? (rem_sh - {1'b0, dsr_ff}) : rem_sh;
         dvd_in  = {dvd_ff[47:0], fits};
         step_in = step_ff + 6'd1;
         if (step_ff == 6'(DIV_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

/* rtl/osa_ctrl.sv */
// Sequencer for query, key, value and finish requests
module osa_ctrl
   import osa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (status.kind)
               REQ_QUERY: begin
                  cmd.q_we = status.idx_ok;
                  state_in = ST_IDLE;
               end
               REQ_KEY:   state_in = status.idx_ok ? ST_K_MUL : ST_IDLE;
               REQ_VALUE: state_in = status.idx_ok ? ST_V_MUL : ST_IDLE;
               REQ_FINISH: begin
                  cmd.f_clr = 1'b1;
                  state_in  = ST_F_RD;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_K_MUL: begin
            cmd.k_mul = 1'b1;
            state_in  = ST_K_ACC;
         end
         ST_K_ACC: begin
            cmd.k_acc = 1'b1;
            state_in  = status.idx_last ? ST_K_SCALE : ST_IDLE;
         end
         ST_K_SCALE: begin
            cmd.k_scale = 1'b1;
            state_in    = ST_K_CMP;
         end
         ST_K_CMP: begin
            cmd.k_cmp = 1'b1;
            state_in  = ST_K_UPD;
         end
         ST_K_UPD: begin
            cmd.k_upd = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_V_MUL: begin
            cmd.v_mul = 1'b1;
            state_in  = ST_V_WR;
         end
         ST_V_WR: begin
            cmd.v_wr = 1'b1;
            state_in = ST_IDLE;
         end
         ST_F_RD: state_in = ST_F_START;
         ST_F_START: begin
            cmd.f_start = 1'b1;
            state_in    = ST_F_WAIT;
         end
         ST_F_WAIT: begin
            if (status.div_done) begin
               cmd.f_out = 1'b1;
               if (status.cnt_last) begin
                  cmd.row_clr = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  cmd.f_next = 1'b1;
                  state_in   = ST_F_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* rtl/osa_dp.sv */
// Datapath: stores, dot product, softmax bookkeeping and output division
module osa_dp
   import osa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [1:0]         req_type,
   input  logic [IDX_W-1:0]   req_elem_index,
   input  logic signed [15:0] req_data_value,
   input  logic               csr_we,
   input  logic [0:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   output logic               rsp_strobe,
   output logic signed [15:0] rsp_out_value,
   output logic [IDX_W-1:0]   rsp_out_index,
   output logic               rsp_last_out
);

   // configuration
   logic [DIM_W-1:0] dim_ff;
   logic [15:0]      scale_ff;
   logic [DIM_W-1:0] dim;

   // request capture
   req_kind_type       kind_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic signed [15:0] data_ff;

   // stores
   logic signed [15:0] q_mem [DIM_MAX];
   logic signed [47:0] acc_mem [DIM_MAX];
   logic [DIM_MAX-1:0] accv_ff;
   logic signed [15:0] q_rd_ff;
   logic signed [47:0] acc_rd_ff;
   logic               accv_rd_ff;
   logic [IDX_W-1:0]   acc_raddr;

   // row state
   logic signed [39:0] dot_ff, dot_in;
   logic signed [39:0] rmax_ff;
   logic               mvalid_ff;
   logic [31:0]        sum_ff, sum_in;
   logic [16:0]        weight_ff;
   logic [16:0]        resc_ff, resc_in;
   logic [16:0]        corr_ff;

   // pipeline registers
   logic signed [31:0] prod_ff;
   logic signed [56:0] sprod_ff;
   logic signed [65:0] vprod_ff;
   logic signed [33:0] wv_ff;
   logic [IDX_W-1:0]   cnt_ff;
   logic               neg_ff;

   // working values
   logic signed [40:0] dot_sum;
   logic signed [40:0] score;
   logic signed [40:0] diff;
   logic signed [40:0] xexp;
   logic               new_max;
   logic [41:0]        eidx;
   logic [16:0]        evalue;
   logic [48:0]        sprod_sum;
   logic [33:0]        sum_next;
   logic [33:0]        resc_prod;
   logic signed [47:0] acc_a;
   logic signed [50:0] acc_next;
   logic signed [47:0] acc_sat;
   logic [47:0]        mag;
   logic [48:0]        dividend;
   logic              div_done;
   logic [48:0]       quot;
   logic signed [15:0] qout;

   // clamp row length to between one and the store depth
   always_comb begin
      if (dim_ff == '0) dim = DIM_W'(1);
      else if (dim_ff > DIM_W'(DIM_MAX)) dim = DIM_W'(DIM_MAX);
      else dim = dim_ff;
   end

   // take configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff   <= DIM_W'(DIM_MAX);
         scale_ff <= 16'd8192;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DIM:   dim_ff   <= csr_wdata[DIM_W-1:0];
            CSR_SCALE: scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // hold the accepted request
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind_type'(req_type);
         idx_ff  <= req_elem_index;
         data_ff <= req_data_value;
      end
   end

   assign status.kind     = kind_ff;
   assign status.idx_ok   = {1'b0, idx_ff} < dim;
   assign status.idx_last = {1'b0, idx_ff} == (dim - DIM_W'(1));
   assign status.cnt_last = {1'b0, cnt_ff} == (dim - DIM_W'(1));
   assign status.div_done = div_done;

   // query store
   always_ff @(posedge clock) begin
      if (cmd.q_we) q_mem[idx_ff] <= data_ff;
      q_rd_ff <= q_mem[idx_ff];
   end

   // accumulator store, entries read as zero until written in this row
   assign acc_raddr = (kind_ff == REQ_FINISH) ? cnt_ff : idx_ff;

   always_ff @(posedge clock) begin
      if (cmd.v_wr) acc_mem[idx_ff] <= acc_sat;
      acc_rd_ff <= acc_mem[acc_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.row_clr) accv_ff <= '0;
      else if (cmd.v_wr) accv_ff[idx_ff] <= 1'b1;
      accv_rd_ff <= accv_ff[acc_raddr];
   end

   // key path: dot product, score, exponent lookup and running sum and rescale update
   always_comb begin
      dot_sum = 41'(dot_ff) + 41'(prod_ff);
      if (dot_sum > 41'sh7F_FFFF_FFFF) dot_in = 40'sh7F_FFFF_FFFF;
      else if (dot_sum < -41'sh80_0000_0000) dot_in = -40'sh80_0000_0000;
      else dot_in = dot_sum[39:0];

      score   = 41'(sprod_ff >>> 28);
      diff    = score - 41'(rmax_ff);
      new_max = !mvalid_ff || (diff > 41'sd0);
      xexp    = new_max ? diff : -diff;
      eidx    = {1'b0, xexp} + 42'(1 << (15 - EXP_TABLE_BITS));
      eidx    = eidx >> (16 - EXP_TABLE_BITS);
      if (eidx >= 42'(EXP_TABLE_SIZE)) evalue = '0;
      else evalue = EXP_TAB[eidx[EXP_TABLE_BITS-1:0]];

      sprod_sum = 49'(sum_ff) * 49'(corr_ff);
      sum_next  = 34'(sprod_sum >> 16) + 34'(weight_ff);
      sum_in    = (sum_next > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum_next[31:0];
      resc_prod = 34'(resc_ff) * 34'(corr_ff);
      resc_in   = resc_prod[32:16];
   end

   // value path: rescale and add weight times value
   always_comb begin
      acc_a    = accv_rd_ff ? acc_rd_ff : 48'sd0;
      acc_next = 51'(vprod_ff >>> 16) + 51'(wv_ff);
      if (acc_next > 51'sh7FFF_FFFF_FFFF) acc_sat = 48'sh7FFF_FFFF_FFFF;
      else if (acc_next < -51'sh8000_0000_0000) acc_sat = -48'sh8000_0000_0000;
      else acc_sat = acc_next[47:0];
   end

   // row state registers
   always_ff @(posedge clock) begin
      if (reset || cmd.row_clr) begin
         dot_ff    <= '0;
         rmax_ff   <= '0;
         mvalid_ff <= 1'b0;
         sum_ff    <= '0;
         weight_ff <= '0;
         resc_ff   <= 17'h10000;
         corr_ff   <= '0;
      end else begin
         if (cmd.k_acc) dot_ff <= dot_in;
         if (cmd.k_cmp) begin
            dot_ff <= '0;
            if (new_max) begin
               corr_ff   <= mvalid_ff ? evalue : 17'd0;
               rmax_ff   <= 40'(score);
               mvalid_ff <= 1'b1;
               weight_ff <= 17'h10000;
            end else begin
               corr_ff   <= 17'h10000;
               weight_ff <= evalue;
            end
         end
         if (cmd.k_upd) begin
            sum_ff  <= sum_in;
            resc_ff <= resc_in;
         end
         if (cmd.v_wr && status.idx_last) resc_ff <= 17'h10000;
      end
   end

   // multiplier stages
   always_ff @(posedge clock) begin
      if (cmd.k_mul) prod_ff <= q_rd_ff * data_ff;
      if (cmd.k_scale) sprod_ff <= 57'(dot_ff) * $signed({41'd0, scale_ff});
      if (cmd.v_mul) begin
         vprod_ff <= 66'(acc_a) * $signed({49'd0, resc_ff});
         wv_ff    <= 34'($signed({1'b0, weight_ff})) * 34'(data_ff);
      end
   end

   // finish: divide magnitude by running sum, rounded
   assign mag      = acc_a[47] ? 48'(-acc_a) : 48'(acc_a);
   assign dividend = 49'(mag) + 49'(sum_ff >> 1);

   always_ff @(posedge clock) begin
      if (cmd.f_clr) cnt_ff <= '0;
      else if (cmd.f_next) cnt_ff <= cnt_ff + IDX_W'(1);
      if (cmd.f_start) neg_ff <= acc_a[47];
   end

   osa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.f_start),
      .dividend (dividend),
      .divisor  (sum_ff),
      .done     (div_done),
      .quotient (quot)
   );

   always_comb begin
      if (sum_ff == '0) qout = '0;
      else if (neg_ff) qout = (quot >= 49'd32768) ? -16'sd32768 : -$signed(quot[15:0]);
      else qout = (quot >= 49'd32767) ? 16'sd32767 : $signed(quot[15:0]);
   end

   // drive the result for one cycle
   always_ff @(posedge clock) begin
      if (reset) rsp_strobe <= 1'b0;
      else rsp_strobe <= cmd.f_out;
      if (cmd.f_out) begin
         rsp_out_value <= qout;
         rsp_out_index <= cnt_ff;
         rsp_last_out  <= status.cnt_last;
      end
   end

endmodule

/* rtl/online_softmax_attention_row_top.sv */
// Online softmax attention row: one query row against streamed key/value rows.
// Each request is taken when start is high and busy is low. Of the query, key
// and value elements, the closing key element of a row keeps the block busy
// longest, as it also runs the score scale, compare and update states. Finish
// emits one result per row element, each after a division in the one-bit-per-
// cycle divider; each result sits on rsp_ ports for one cycle with rsp_strobe high
// and the receiver must take it, it cannot stall the block.
module online_softmax_attention_row_top
   import osa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_type,
   input  logic [IDX_W-1:0]   req_elem_index,
   input  logic signed [15:0] req_data_value,
   output logic               rsp_strobe,
   output logic signed [15:0] rsp_out_value,
   output logic [IDX_W-1:0]   rsp_out_index,
   output logic               rsp_last_out,
   input  logic               csr_we,
   input  logic [0:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

`include "online_softmax_attention_row_top_assert.svh"

   cmd_type    cmd;
   status_type status;

   osa_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   osa_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_type       (req_type),
      .req_elem_index (req_elem_index),
      .req_data_value (req_data_value),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_strobe     (rsp_strobe),
      .rsp_out_value  (rsp_out_value),
      .rsp_out_index  (rsp_out_index),
      .rsp_last_out   (rsp_last_out)
   );

   // accepted request keeps the block busy
   `OSA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // last result ends the burst
   `OSA_ASSERT_NEXT(a_last_ends, clock, reset, rsp_strobe && rsp_last_out, !rsp_strobe)
   // results are single-cycle strobes
   `OSA_ASSERT_NEXT(a_strobe_pulse, clock, reset, rsp_strobe, !rsp_strobe)
   // a result other than the last leaves the block busy
   `OSA_ASSERT_SAME(a_mid_busy, clock, reset, rsp_strobe && !rsp_last_out, busy)

endmodule

/* tb/sv/tb_top.sv */
// Testbench for the online softmax attention row block: directed table, then random rows
`timescale 1ns / 1ps

module tb_top;
   import osa_pkg::*;

   typedef struct {
      logic signed [15:0] value;
      logic [5:0]         index;
      logic               last;
   } attn_out_type;

   typedef struct {
      bit           csr;
      logic [1:0]   kind;
      int           idx;
      logic [15:0]  data;
      bit           typed;
      logic [15:0]  typed_value;
   } stim_row_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_type;
   logic [IDX_W-1:0]   req_elem_index;
   logic signed [15:0] req_data_value;
   logic               rsp_strobe;
   logic signed [15:0] rsp_out_value;
   logic [IDX_W-1:0]   rsp_out_index;
   logic               rsp_last_out;
   logic               csr_we;
   logic [0:0]         csr_index;
   logic [15:0]        csr_wdata;

   localparam longint ACC_HI = 64'sh7FFFFFFFFFFF;
   localparam longint ACC_LO = -ACC_HI - 1;
   localparam longint DOT_HI = 64'sh7FFFFFFFFF;
   localparam longint DOT_LO = -DOT_HI - 1;
   localparam int     CYCLE_LIMIT = 3000000;

   // predictor state
   longint unsigned exp_q16 [256];
   logic [6:0]      dim_reg;
   logic [15:0]     scale_reg;
   longint          query_row [64];
   bit              query_set [64];
   longint          accum_row [64];
   longint          dot_sum;
   longint          best_score;
   bit              best_valid;
   longint unsigned weight_sum;
   longint unsigned weight_now;
   longint unsigned rescale_now;

   attn_out_type    expected_outputs [$];
   int              error_count;
   int              cycle_count;
   int              request_count;
   int              output_count;
   int              phase_count;
   bit              idle_on;

   online_softmax_attention_row_top dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // exp(-i*step) table in Q1.16 from a truncated Taylor series
   function automatic void fill_exp_table();
      longint unsigned step_q30;
      longint unsigned term;
      longint unsigned e;
      longint          r;
      step_q30 = 64'd1 << 26;
      term = 64'd1 << 30;
      r = longint'(term);
      e = 64'd1 << 30;
      for (int k = 1; k <= 24; k++) begin
         term = ((term * step_q30) >> 30) / longint'(k);
         if (k % 2 == 1) r = r - longint'(term);
         else r = r + longint'(term);
      end
      if (r < 0) r = 0;
      for (int i = 0; i < 256; i++) begin
         if (i > 0) e = (e * longint'(r) + (64'd1 << 29)) >> 30;
         exp_q16[i] = (e + (64'd1 << 13)) >> 14;
      end
   endfunction

   function automatic longint unsigned exp_of_neg(longint x);
      longint unsigned pos;
      pos = (x < 0) ? 0 : x;
      pos = (pos + 64'd128) >> 8;
      return (pos >= 256) ? 0 : exp_q16[pos];
   endfunction

   function automatic int row_len();
      if (dim_reg == 0) return 1;
      if (dim_reg > 64) return 64;
      return int'(dim_reg);
   endfunction

   function automatic void clear_row_state();
      for (int i = 0; i < 64; i++) accum_row[i] = 0;
      dot_sum = 0;
      best_score = 0;
      best_valid = 0;
      weight_sum = 0;
      weight_now = 0;
      rescale_now = 65536;
   endfunction

   function automatic longint clip(longint x, longint lo, longint hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
   endfunction

   // advance the predictor by one request; finish results go to the queue
   function automatic void predict_attention(req_kind_type kind, int idx, logic [15:0] data,
                                             bit typed, logic [15:0] typed_value);
      longint          v;
      longint          score;
      longint          a;
      longint unsigned corr;
      longint unsigned mag;
      longint unsigned qm;
      longint          q;
      int              n;
      attn_out_type    o;
      v = longint'(signed'(data));
      n = row_len();
      if (kind == REQ_FINISH) begin
         for (int i = 0; i < n; i++) begin
            q = 0;
            if (weight_sum != 0) begin
               a = accum_row[i];
               mag = (a < 0) ? -a : a;
               qm = (mag + weight_sum / 2) / weight_sum;
               if (qm > 40000) qm = 40000;
               q = (a < 0) ? -longint'(qm) : longint'(qm);
               q = clip(q, -32768, 32767);
            end
            o.value = typed ? typed_value : q[15:0];
            o.index = i[5:0];
            o.last  = (i == n - 1);
            expected_outputs.push_back(o);
         end
         clear_row_state();
         return;
      end
      if (idx >= n) return;
      if (kind == REQ_QUERY) begin
         query_row[idx] = v;
         query_set[idx] = 1;
      end else if (kind == REQ_KEY) begin
         dot_sum = clip(dot_sum + query_row[idx] * v, DOT_LO, DOT_HI);
         if (idx == n - 1) begin
            score = (dot_sum * longint'(scale_reg)) >>> 28;
            dot_sum = 0;
            if (!best_valid || score > best_score) begin
               corr = best_valid ? exp_of_neg(score - best_score) : 0;
               best_score = score;
               best_valid = 1;
               weight_now = 65536;
            end else begin
               corr = 65536;
               weight_now = exp_of_neg(best_score - score);
            end
            weight_sum = ((weight_sum * corr) >> 16) + weight_now;
            if (weight_sum > 64'hFFFFFFFF) weight_sum = 64'hFFFFFFFF;
            rescale_now = (rescale_now * corr) >> 16;
         end
      end else begin
         a = accum_row[idx];
         if (rescale_now < 65536) a = (a * longint'(rescale_now)) >>> 16;
         a = a + longint'(weight_now) * v;
         accum_row[idx] = clip(a, ACC_LO, ACC_HI);
         if (idx == n - 1) rescale_now = 65536;
      end
   endfunction

   task automatic report_mismatch(string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // drop start, hold until every expected output has come, then let the pipeline drain
   task automatic wait_drained();
      @(negedge clock);
      start = 1'b0;
      while (expected_outputs.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type which, logic [15:0] value);
      wait_drained();
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = which;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      if (which == CSR_DIM) dim_reg = value[6:0];
      else scale_reg = value;
   endtask

   task automatic send_request(req_kind_type kind, int idx, logic [15:0] data,
                               bit typed = 0, logic [15:0] typed_value = '0);
      @(negedge clock);
      if (idle_on && $urandom_range(99) < 38) begin
         start = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      start = 1'b1;
      req_type = kind;
      req_elem_index = idx[5:0];
      req_data_value = data;
      do @(posedge clock); while (busy);
      predict_attention(kind, idx, data, typed, typed_value);
      request_count++;
   endtask

   function automatic logic [15:0] pick_data();
      case ($urandom_range(5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2, 3: return 16'($urandom_range(0, 8191)) - 16'd4096;
         default: return 16'($urandom);
      endcase
   endfunction

   // compare each output with the oldest expectation
   always @(posedge clock) begin
      attn_out_type e;
      if (!reset && rsp_strobe) begin
         output_count++;
         if (expected_outputs.size() == 0) begin
            report_mismatch($sformatf("unexpected output idx %0d", rsp_out_index));
         end else begin
            e = expected_outputs.pop_front();
            if (rsp_out_value !== e.value)
               report_mismatch($sformatf("idx %0d value %0d, want %0d",
                                         e.index, rsp_out_value, e.value));
            if (rsp_out_index !== e.index)
               report_mismatch($sformatf("index %0d, want %0d", rsp_out_index, e.index));
            if (rsp_last_out !== e.last)
               report_mismatch($sformatf("idx %0d last %0b, want %0b",
                                         e.index, rsp_last_out, e.last));
         end
      end
   end

   // stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   stim_row_type directed_rows [] = '{
      '{0, REQ_FINISH, 0, 16'h0000, 1, 16'h0000},
      '{1, CSR_DIM,    0, 16'd2,    0, 16'h0000},
      '{1, CSR_SCALE,  0, 16'hFFFF, 0, 16'h0000},
      '{0, REQ_QUERY,  0, 16'h7FFF, 0, 16'h0000},
      '{0, REQ_QUERY,  1, 16'h8000, 0, 16'h0000},
      '{0, REQ_QUERY,  5, 16'd123,  0, 16'h0000},
      '{0, REQ_KEY,    0, 16'h7FFF, 0, 16'h0000},
      '{0, REQ_KEY,    1, 16'h8000, 0, 16'h0000},
      '{0, REQ_VALUE,  0, 16'h7FFF, 0, 16'h0000},
      '{0, REQ_VALUE,  1, 16'h8000, 0, 16'h0000},
      '{0, REQ_KEY,    0, 16'h8000, 0, 16'h0000},
      '{0, REQ_KEY,    1, 16'h7FFF, 0, 16'h0000},
      '{0, REQ_VALUE,  0, 16'd1000, 0, 16'h0000},
      '{0, REQ_VALUE,  1, -16'd1000, 0, 16'h0000},
      '{0, REQ_KEY,    0, 16'h7FFF, 0, 16'h0000},
      '{0, REQ_KEY,    1, 16'h7FFF, 0, 16'h0000},
      '{0, REQ_VALUE,  0, 16'h8000, 0, 16'h0000},
      '{0, REQ_VALUE,  1, 16'h7FFF, 0, 16'h0000},
      '{0, REQ_VALUE,  3, 16'd5,    0, 16'h0000},
      '{0, REQ_FINISH, 0, 16'h0000, 0, 16'h0000},
      '{0, REQ_FINISH, 0, 16'h0000, 1, 16'h0000},
      '{1, CSR_SCALE,  0, 16'h0000, 0, 16'h0000},
      '{0, REQ_KEY,    0, 16'd100,  0, 16'h0000},
      '{0, REQ_KEY,    1, 16'd100,  0, 16'h0000},
      '{0, REQ_VALUE,  0, 16'd4096, 0, 16'h0000},
      '{0, REQ_VALUE,  1, -16'd4096, 0, 16'h0000},
      '{0, REQ_FINISH, 0, 16'h0000, 0, 16'h0000}
   };

   initial begin
      int          n;
      int          rows;
      logic [15:0] d;
      req_kind_type k;
      start = 1'b0;
      req_type = REQ_QUERY;
      req_elem_index = '0;
      req_data_value = '0;
      csr_we = 1'b0;
      csr_index = CSR_DIM;
      csr_wdata = '0;
      reset = 1'b1;
      error_count = 0;
      cycle_count = 0;
      request_count = 0;
      output_count = 0;
      phase_count = 0;
      idle_on = 1;
      fill_exp_table();
      dim_reg = 7'd64;
      scale_reg = 16'd8192;
      for (int i = 0; i < 64; i++) begin
         query_row[i] = 0;
         query_set[i] = 0;
      end
      clear_row_state();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // walk the directed table
      foreach (directed_rows[r]) begin
         if (directed_rows[r].csr)
            write_csr(csr_index_type'(directed_rows[r].kind[0]), directed_rows[r].data);
         else
            send_request(req_kind_type'(directed_rows[r].kind), directed_rows[r].idx,
                         directed_rows[r].data, directed_rows[r].typed,
                         directed_rows[r].typed_value);
      end

      // random phases: new settings, full query row, key/value rows, finish
      while (request_count < 460) begin
         phase_count++;
         // keep late phases short so the run ends near its request budget
         if (request_count >= 300) begin
            write_csr(CSR_DIM, 16'($urandom_range(1, 8)));
         end else begin
            case ($urandom_range(9))
               0: write_csr(CSR_DIM, 16'($urandom_range(0, 1)));
               1: write_csr(CSR_DIM, 16'h0000 | (16'($urandom) & 16'hFF80) | 16'd127);
               2: write_csr(CSR_DIM, 16'd64);
               default: write_csr(CSR_DIM, 16'($urandom_range(1, 8)));
            endcase
         end
         case ($urandom_range(4))
            0: write_csr(CSR_SCALE, 16'h0000);
            1: write_csr(CSR_SCALE, 16'hFFFF);
            2: write_csr(CSR_SCALE, 16'd8192);
            default: write_csr(CSR_SCALE, 16'($urandom));
         endcase
         if (phase_count == 4) wait_drained();
         n = row_len();
         idle_on = !(request_count >= 200 && request_count < 300);
         for (int i = 0; i < n; i++) send_request(REQ_QUERY, i, pick_data());
         rows = (n > 8) ? 1 : $urandom_range(1, 5);
         for (int r = 0; r < rows; r++) begin
            for (int i = 0; i < n; i++) send_request(REQ_KEY, i, pick_data());
            for (int i = 0; i < n; i++) begin
               send_request(REQ_VALUE, i, pick_data());
               // drop a stray or out-of-range request into the stream now and then
               if ($urandom_range(99) < 10) begin
                  k = req_kind_type'($urandom_range(0, 2));
                  send_request(k, $urandom_range(0, 63), pick_data());
               end
            end
            idle_on = !(request_count >= 200 && request_count < 300);
         end
         send_request(REQ_FINISH, $urandom_range(0, 63), 16'($urandom));
      end

      @(negedge clock);
      start = 1'b0;
      while (expected_outputs.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Covered %0d requests over %0d setting phases, %0d outputs checked.",
               request_count, phase_count, output_count);
      $display("Row sizes ran from one element to the full row, scale from zero to max.");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
